[rtl/fat_short_name_directory_lookup_defines.svh]
// Assertion macros used by the port-level checker of the directory lookup block.
`ifndef FAT_SHORT_NAME_DIRECTORY_LOOKUP_DEFINES_SVH
`define FAT_SHORT_NAME_DIRECTORY_LOOKUP_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low
`define FSNDL_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low
`define FSNDL_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[rtl/fsndl_pkg.sv]
// Types and constants for the FAT 8.3 short-name directory lookup block.
package fsndl_pkg;

  // Command codes of an input transaction
  typedef enum logic [0:0] {
    CMD_CHAR  = 1'b0,
    CMD_ENTRY = 1'b1
  } cmd_e;

  localparam int unsigned NameLen = 8;
  localparam int unsigned ExtLen  = 3;

  localparam logic [7:0] CharSpace   = 8'h20;
  localparam logic [7:0] CharDot     = 8'h2E;
  localparam logic [7:0] CharLowA    = 8'h61;
  localparam logic [7:0] CharLowZ    = 8'h7A;
  localparam logic [7:0] CaseOffset  = 8'd32;
  localparam logic [7:0] DeletedMark = 8'hE5;
  localparam logic [7:0] LongNameAttr = 8'h0F;

  localparam logic [63:0] NameBlank = {NameLen{CharSpace}};
  localparam logic [23:0] ExtBlank  = {ExtLen{CharSpace}};

  localparam logic [31:0] DataStartReset = 32'd2112;

  // Input transaction payload
  typedef struct packed {
    logic        command;
    logic [7:0]  name_char;
    logic        last_char;
    logic [63:0] entry_name;
    logic [23:0] entry_ext;
    logic [7:0]  entry_attr;
    logic [31:0] entry_size;
  } in_item_t;

  // Output transaction payload
  typedef struct packed {
    logic        found;
    logic [3:0]  entry_index;
    logic [31:0] data_sector;
    logic [31:0] file_size;
  } out_item_t;

  // Packed 8.3 query
  typedef struct packed {
    logic [63:0] name;
    logic [23:0] ext;
  } query_t;

  // Search control from the query builder to the matcher
  typedef struct packed {
    logic start;
    logic abort;
  } srch_ctl_t;

endpackage

[rtl/fsndl_query.sv]
// Query builder: packs filename characters into space-padded 8.3 form.
module fsndl_query (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  char_valid_i,
  input  logic [7:0]            char_i,
  input  logic                  last_i,
  output fsndl_pkg::query_t     query_o,
  output fsndl_pkg::srch_ctl_t  ctl_o
);
  import fsndl_pkg::*;

  logic [63:0] name_q, name_d, name_base;
  logic [23:0] ext_q, ext_d, ext_base;
  logic        in_ext_q, in_ext_d, in_ext_base;
  logic [3:0]  name_cnt_q, name_cnt_d, name_cnt_base;
  logic [1:0]  ext_cnt_q, ext_cnt_d, ext_cnt_base;
  logic        complete_q, complete_d;
  logic [7:0]  up_char;

  // Upper-case a..z only
  assign up_char = (char_i inside {[CharLowA:CharLowZ]}) ? (char_i - CaseOffset) : char_i;

  // A character after a finished query starts from a blank query
  always_comb begin
    name_base     = complete_q ? NameBlank : name_q;
    ext_base      = complete_q ? ExtBlank  : ext_q;
    in_ext_base   = complete_q ? 1'b0 : in_ext_q;
    name_cnt_base = complete_q ? 4'd0 : name_cnt_q;
    ext_cnt_base  = complete_q ? 2'd0 : ext_cnt_q;
  end

  // Character insert
  always_comb begin
    name_d     = name_q;
    ext_d      = ext_q;
    in_ext_d   = in_ext_q;
    name_cnt_d = name_cnt_q;
    ext_cnt_d  = ext_cnt_q;
    complete_d = complete_q;
    if (char_valid_i) begin
      name_d     = name_base;
      ext_d      = ext_base;
      in_ext_d   = in_ext_base;
      name_cnt_d = name_cnt_base;
      ext_cnt_d  = ext_cnt_base;
      complete_d = last_i;
      if (char_i != 8'd0) begin
        if (!in_ext_base && char_i == CharDot) begin
          in_ext_d = 1'b1;
        end else if (!in_ext_base) begin
          if (name_cnt_base < 4'(NameLen)) begin
            for (int b = 0; b < NameLen; b++) begin
              if (name_cnt_base == 4'(b)) name_d[8*b +: 8] = up_char;
            end
            name_cnt_d = name_cnt_base + 4'd1;
          end
        end else begin
          if (ext_cnt_base < 2'(ExtLen)) begin
            for (int b = 0; b < ExtLen; b++) begin
              if (ext_cnt_base == 2'(b)) ext_d[8*b +: 8] = up_char;
            end
            ext_cnt_d = ext_cnt_base + 2'd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      name_q     <= NameBlank;
      ext_q      <= ExtBlank;
      in_ext_q   <= 1'b0;
      name_cnt_q <= 4'd0;
      ext_cnt_q  <= 2'd0;
      complete_q <= 1'b1;
    end else begin
      name_q     <= name_d;
      ext_q      <= ext_d;
      in_ext_q   <= in_ext_d;
      name_cnt_q <= name_cnt_d;
      ext_cnt_q  <= ext_cnt_d;
      complete_q <= complete_d;
    end
  end

  // Last character starts a search; any other character cancels one
  assign ctl_o.start  = char_valid_i && last_i;
  assign ctl_o.abort  = char_valid_i && !last_i;
  assign query_o.name = name_q;
  assign query_o.ext  = ext_q;

endmodule

[rtl/fsndl_match.sv]
// Entry matcher: compares directory entries against the query and tracks the scan.
module fsndl_match #(
  parameter int unsigned DIR_ENTRIES = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  entry_valid_i,
  input  fsndl_pkg::in_item_t   entry_i,
  input  fsndl_pkg::query_t     query_i,
  input  fsndl_pkg::srch_ctl_t  ctl_i,
  input  logic [31:0]           data_start_i,
  output logic                  res_valid_o,
  output fsndl_pkg::out_item_t  res_o
);
  import fsndl_pkg::*;

  localparam int unsigned IdxW = (DIR_ENTRIES > 1) ? $clog2(DIR_ENTRIES) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(DIR_ENTRIES - 1);

  logic [IdxW-1:0] scan_q, scan_d;
  logic            finished_q, finished_d;
  logic [7:0]      first_byte;
  logic            hit;
  logic [31:0]     idx_ext;

  assign first_byte = entry_i.entry_name[7:0];
  assign idx_ext    = 32'(scan_q);

  // Live entry whose 11 name bytes equal the query
  assign hit = (first_byte != DeletedMark) && (entry_i.entry_attr != LongNameAttr)
            && (entry_i.entry_name == query_i.name) && (entry_i.entry_ext == query_i.ext);

  // Scan control and result
  always_comb begin
    scan_d      = scan_q;
    finished_d  = finished_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    if (ctl_i.start) begin
      scan_d     = '0;
      finished_d = 1'b0;
    end else if (ctl_i.abort) begin
      finished_d = 1'b1;
    end else if (entry_valid_i && !finished_q) begin
      if (first_byte == 8'd0) begin
        finished_d  = 1'b1;
        res_valid_o = 1'b1;
      end else if (hit) begin
        finished_d        = 1'b1;
        res_valid_o       = 1'b1;
        res_o.found       = 1'b1;
        res_o.entry_index = idx_ext[3:0];
        res_o.data_sector = data_start_i + idx_ext;
        res_o.file_size   = entry_i.entry_size;
      end else begin
        scan_d = scan_q + 1'b1;
        if (scan_q == LastIdx) begin
          finished_d  = 1'b1;
          res_valid_o = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q     <= '0;
      finished_q <= 1'b1;
    end else begin
      scan_q     <= scan_d;
      finished_q <= finished_d;
    end
  end

endmodule

[rtl/fat_short_name_directory_lookup.sv]
// Top level of the FAT 8.3 short-name directory lookup block.
// Takes one transaction per cycle while in_stall_o is low: a query filename
// character (command 0) or a root directory entry (command 1). Each
// transaction is captured in an input register, handled by the query builder
// or the entry matcher, and any result lands in an output register that
// drives the output. The single compare stage between those registers sets
// the rate of one transaction per clock while the output is not stalled.
// in_stall_o rises only while a result waits on a stalled output and the
// input register is also occupied. The data start sector register is written
// through the cfg port, which is always ready.
module fat_short_name_directory_lookup #(
  parameter int unsigned DIR_ENTRIES = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  fsndl_pkg::in_item_t   in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output fsndl_pkg::out_item_t  out_data_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [31:0]           cfg_data_i
);
  import fsndl_pkg::*;

  in_item_t   in_q;
  logic       in_valid_q;
  out_item_t  out_q;
  logic       out_valid_q;
  logic [31:0] data_start_q;
  logic       advance, proc, accept;
  logic       char_valid, entry_valid;
  query_t     query;
  srch_ctl_t  ctl;
  logic       res_valid;
  out_item_t  res;

  // Handshake
  assign advance    = !out_valid_q || !out_stall_i;
  assign proc       = in_valid_q && advance;
  assign in_stall_o = in_valid_q && !advance;
  assign accept     = in_valid_i && !in_stall_o;

  assign char_valid  = proc && (in_q.command == CMD_CHAR);
  assign entry_valid = proc && (in_q.command == CMD_ENTRY);

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (accept) begin
      in_valid_q <= 1'b1;
    end else if (proc) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q <= in_data_i;
    end
  end

  // Configuration register
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_start_q <= DataStartReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      data_start_q <= cfg_data_i;
    end
  end

  fsndl_query u_query (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .char_valid_i (char_valid),
    .char_i       (in_q.name_char),
    .last_i       (in_q.last_char),
    .query_o      (query),
    .ctl_o        (ctl)
  );

  fsndl_match #(
    .DIR_ENTRIES (DIR_ENTRIES)
  ) u_match (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .entry_valid_i (entry_valid),
    .entry_i       (in_q),
    .query_i       (query),
    .ctl_i         (ctl),
    .data_start_i  (data_start_q),
    .res_valid_o   (res_valid),
    .res_o         (res)
  );

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (proc && res_valid) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

[rtl/fsndl_checker.sv]
// Port-level checker for the directory lookup block, with its bind.
`include "fat_short_name_directory_lookup_defines.svh"

module fsndl_checker (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_stall_o,
  input fsndl_pkg::in_item_t   in_data_i,
  input logic                  out_valid_o,
  input logic                  out_stall_i,
  input fsndl_pkg::out_item_t  out_data_o,
  input logic                  cfg_valid_i,
  input logic                  cfg_ready_o
);
  import fsndl_pkg::*;

  // A stalled input transaction stays put
  `FSNDL_ASSERT_NXT(a_in_hold, in_valid_i && in_stall_o,
                    in_valid_i && $stable(in_data_i))

  // A held result keeps its payload
  `FSNDL_ASSERT_NXT(a_out_hold, out_valid_o && out_stall_i,
                    out_valid_o && $stable(out_data_o))

  // Not-found results carry all-zero fields
  `FSNDL_ASSERT_IMP(a_miss_zero, out_valid_o && !out_data_o.found,
                    (out_data_o.entry_index == 4'd0) && (out_data_o.data_sector == 32'd0)
                    && (out_data_o.file_size == 32'd0))

  // Input backpressure only while a result is held on the output
  `FSNDL_ASSERT_IMP(a_stall_cause, in_stall_o, out_valid_o && out_stall_i)

  // Config port never blocks
  `FSNDL_ASSERT_IMP(a_cfg_ready, cfg_valid_i, cfg_ready_o)

endmodule

bind fat_short_name_directory_lookup fsndl_checker u_fsndl_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o),
  .cfg_valid_i (cfg_valid_i),
  .cfg_ready_o (cfg_ready_o)
);

[sim/fat_short_name_directory_lookup_checker.sv]
// Channel monitor, 8.3 lookup predictor and result comparison for the directory lookup block.
module fat_short_name_directory_lookup_checker #(
  parameter int unsigned DirEntries = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_stall_i,
  input  fsndl_pkg::in_item_t  in_data_i,
  input  logic                 out_valid_i,
  input  logic                 out_stall_i,
  input  fsndl_pkg::out_item_t out_data_i,
  input  logic                 cfg_valid_i,
  input  logic                 cfg_ready_i,
  input  logic [31:0]          cfg_data_i,
  output int unsigned          err_count_o,
  output int unsigned          pending_o,
  output int unsigned          lookup_count_o,
  output int unsigned          hit_count_o
);
  import fsndl_pkg::*;

  // Shadow of the query builder and directory scan
  logic [63:0] qry_name;
  logic [23:0] qry_ext;
  logic        in_ext;
  int unsigned name_cnt;
  int unsigned ext_cnt;
  logic        qry_done;
  int unsigned scan_idx;
  logic        search_done;
  logic [31:0] start_sector;

  // Lookup results still owed by the block, oldest first
  out_item_t   lookups_due[$];
  int unsigned errs;
  int unsigned lookups;
  int unsigned hits;

  task automatic clear_lookup();
    start_sector = DataStartReset;
    qry_name     = NameBlank;
    qry_ext      = ExtBlank;
    in_ext       = 1'b0;
    name_cnt     = 0;
    ext_cnt      = 0;
    qry_done     = 1'b1;
    scan_idx     = 0;
    search_done  = 1'b1;
    lookups_due.delete();
    errs         = 0;
    lookups      = 0;
    hits         = 0;
  endtask

  // One query character: upper-case, pack into name or extension
  task automatic track_char(input logic [7:0] raw, input logic last);
    logic [7:0] c;
    c = raw;
    if (qry_done) begin
      qry_name    = NameBlank;
      qry_ext     = ExtBlank;
      in_ext      = 1'b0;
      name_cnt    = 0;
      ext_cnt     = 0;
      qry_done    = 1'b0;
      search_done = 1'b1;
    end
    if (c != 8'h00) begin
      if (c >= CharLowA && c <= CharLowZ) c = c - CaseOffset;
      if (!in_ext && c == CharDot) begin
        in_ext = 1'b1;
      end else if (!in_ext) begin
        if (name_cnt < NameLen) begin
          qry_name[name_cnt*8 +: 8] = c;
          name_cnt++;
        end
      end else if (ext_cnt < ExtLen) begin
        qry_ext[ext_cnt*8 +: 8] = c;
        ext_cnt++;
      end
    end
    if (last) begin
      qry_done    = 1'b1;
      scan_idx    = 0;
      search_done = 1'b0;
    end
  endtask

  // One directory entry against the finished query
  task automatic track_entry(input in_item_t t);
    out_item_t miss;
    out_item_t hit;
    miss = '0;
    if (search_done || !qry_done) return;
    if (t.entry_name[7:0] == 8'h00) begin
      search_done = 1'b1;
      lookups_due.push_back(miss);
    end else if (t.entry_name[7:0] != DeletedMark && t.entry_attr != LongNameAttr &&
                 t.entry_name == qry_name && t.entry_ext == qry_ext) begin
      search_done     = 1'b1;
      hit.found       = 1'b1;
      hit.entry_index = scan_idx[3:0];
      hit.data_sector = start_sector + 32'(scan_idx);
      hit.file_size   = t.entry_size;
      lookups_due.push_back(hit);
    end else begin
      scan_idx++;
      if (scan_idx >= DirEntries) begin
        search_done = 1'b1;
        lookups_due.push_back(miss);
      end
    end
  endtask

  function automatic int unsigned field_mismatch(input string fname, input logic [31:0] want,
                                                 input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %h, got %h", $time, fname, want, got);
      return 1;
    end
    return 0;
  endfunction

  task automatic check_lookup(input out_item_t got);
    out_item_t want;
    if (lookups_due.size() == 0) begin
      $display("%0t: result with none expected: found %b index %0d sector %h size %h",
               $time, got.found, got.entry_index, got.data_sector, got.file_size);
      errs++;
      return;
    end
    want = lookups_due.pop_front();
    lookups++;
    if (want.found) hits++;
    errs += field_mismatch("found", 32'(want.found), 32'(got.found));
    errs += field_mismatch("entry_index", 32'(want.entry_index), 32'(got.entry_index));
    errs += field_mismatch("data_sector", want.data_sector, got.data_sector);
    errs += field_mismatch("file_size", want.file_size, got.file_size);
  endtask

  // Results are checked before the same-edge input, which cannot have produced them yet
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_lookup();
    end else begin
      if (out_valid_i && !out_stall_i) check_lookup(out_data_i);
      if (cfg_valid_i && cfg_ready_i) start_sector = cfg_data_i;
      if (in_valid_i && !in_stall_i) begin
        if (in_data_i.command == CMD_CHAR) begin
          track_char(in_data_i.name_char, in_data_i.last_char);
        end else begin
          track_entry(in_data_i);
        end
      end
    end
    err_count_o    <= errs;
    pending_o      <= lookups_due.size();
    lookup_count_o <= lookups;
    hit_count_o    <= hits;
  end

endmodule

[sim/fat_short_name_directory_lookup_test.sv]
// Testbench top for the directory lookup block: clock, reset, stimulus and verdict.
module fat_short_name_directory_lookup_test;
  import fsndl_pkg::*;

  localparam int unsigned DirEntries  = 16;
  localparam int unsigned QuietLimit  = 2000;  // cycles with no transaction anywhere
  localparam int unsigned RandomTxns  = 1400;
  localparam int unsigned Phases      = 8;
  localparam int unsigned SettleTicks = 4;     // settling wait after the last owed result
  localparam logic [7:0]  CharUpA     = CharLowA - CaseOffset;
  localparam logic [7:0]  CharUpZ     = CharLowZ - CaseOffset;
  localparam logic [7:0]  CharDigit0  = 8'h30;

  typedef enum int {
    ENT_HIT,
    ENT_END,
    ENT_DELETED,
    ENT_LONG,
    ENT_NEAR,
    ENT_OTHER
  } ent_kind_e;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid;
  logic        in_stall_o;
  in_item_t    in_data;
  logic        out_valid_o;
  logic        out_stall;
  out_item_t   out_data_o;
  logic        cfg_valid;
  logic        cfg_ready_o;
  logic [31:0] cfg_data;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned lookup_count;
  int unsigned hit_count;

  int unsigned txn_count;
  int unsigned setting_count;
  int unsigned quiet_cycles;
  bit          steady_flow;

  // Target 8.3 name of the current query, blank padded
  logic [63:0] want_name;
  logic [23:0] want_ext;
  int unsigned want_nl;
  int unsigned want_el;

  fat_short_name_directory_lookup #(
    .DIR_ENTRIES(DirEntries)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data)
  );

  fat_short_name_directory_lookup_checker #(
    .DirEntries(DirEntries)
  ) lookup_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall_o),
    .in_data_i     (in_data),
    .out_valid_i   (out_valid_o),
    .out_stall_i   (out_stall),
    .out_data_i    (out_data_o),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_i   (cfg_ready_o),
    .cfg_data_i    (cfg_data),
    .err_count_o   (fail_count),
    .pending_o     (pending),
    .lookup_count_o(lookup_count),
    .hit_count_o   (hit_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Watchdog: no transaction on any channel for too long
  always @(posedge clk_i) begin
    if ((in_valid && !in_stall_o) || (out_valid_o && !out_stall) || (cfg_valid && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Result side: optionally raise out_stall before taking each result
  initial begin
    int unsigned hold;
    out_stall <= 1'b0;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      hold = steady_flow ? 0 : $urandom_range(0, 4);
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall <= 1'b0;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  // Send one transaction after a random gap; returns at the accepting edge
  task automatic push_txn(input in_item_t t);
    int unsigned gap;
    gap = steady_flow ? 0 : $urandom_range(0, 4);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= t;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    txn_count++;
  endtask

  // Wait until every owed result is in and the block has settled
  task automatic drain_lookups();
    in_valid <= 1'b0;
    repeat (3) @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SettleTicks) @(posedge clk_i);
  endtask

  task automatic write_start_sector(input logic [31:0] value);
    drain_lookups();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid <= 1'b0;
    setting_count++;
  endtask

  // Entry with every field random; fields unused by a character are noise too
  function automatic in_item_t any_entry();
    in_item_t t;
    t.command    = CMD_ENTRY;
    t.name_char  = 8'($urandom);
    t.last_char  = 1'($urandom);
    t.entry_name = {$urandom, $urandom};
    t.entry_ext  = 24'($urandom);
    t.entry_attr = 8'($urandom);
    t.entry_size = $urandom;
    return t;
  endfunction

  function automatic in_item_t char_txn(input logic [7:0] c, input bit last);
    in_item_t t;
    t           = any_entry();
    t.command   = CMD_CHAR;
    t.name_char = c;
    t.last_char = last;
    return t;
  endfunction

  function automatic in_item_t entry_txn(input ent_kind_e kind);
    in_item_t     t;
    logic [87:0]  full;
    t = any_entry();
    if (kind != ENT_OTHER && kind != ENT_END) begin
      t.entry_name = want_name;
      t.entry_ext  = want_ext;
      if (t.entry_attr == LongNameAttr) t.entry_attr = 8'h00;
    end
    case (kind)
      ENT_END:     t.entry_name[7:0] = 8'h00;
      ENT_DELETED: t.entry_name[7:0] = DeletedMark;
      ENT_LONG:    t.entry_attr = LongNameAttr;
      ENT_NEAR: begin
        // one bit off anywhere past the first byte
        full = {t.entry_ext, t.entry_name};
        full[$urandom_range(8, 87)] ^= 1'b1;
        {t.entry_ext, t.entry_name} = full;
      end
      ENT_OTHER: if (t.entry_name[7:0] == 8'h00) t.entry_name[7:0] = 8'($urandom_range(1, 255));
      default: ;
    endcase
    return t;
  endfunction

  function automatic ent_kind_e filler_kind();
    return ent_kind_e'($urandom_range(ENT_DELETED, ENT_OTHER));
  endfunction

  // Stored character: never lower case, dot only on the extension side
  function automatic logic [7:0] pick_char(input bit ext_side);
    logic [7:0] c;
    do begin
      case ($urandom_range(0, 4))
        0, 1, 2: c = CharUpA + 8'($urandom_range(0, 25));
        3:       c = CharDigit0 + 8'($urandom_range(0, 9));
        default: c = 8'($urandom_range(1, 255));
      endcase
    end while ((c >= CharLowA && c <= CharLowZ) || (!ext_side && c == CharDot));
    return c;
  endfunction

  function automatic logic [7:0] mixed_case(input logic [7:0] c);
    if (c >= CharUpA && c <= CharUpZ && $urandom_range(0, 1) == 1) return c + CaseOffset;
    return c;
  endfunction

  task automatic pick_target();
    want_nl   = $urandom_range(0, NameLen);
    want_el   = $urandom_range(0, ExtLen);
    want_name = NameBlank;
    want_ext  = ExtBlank;
    for (int i = 0; i < want_nl; i++) want_name[i*8 +: 8] = pick_char(1'b0);
    for (int i = 0; i < want_el; i++) want_ext[i*8 +: 8] = pick_char(1'b1);
  endtask

  // Spell the target as characters: mixed case, zero characters, overflow
  task automatic send_query(input bit noisy);
    logic [7:0] chars[$];
    for (int i = 0; i < want_nl; i++) begin
      chars.push_back(mixed_case(want_name[i*8 +: 8]));
      if ($urandom_range(0, 11) == 0) chars.push_back(8'h00);
    end
    if (want_nl == NameLen && $urandom_range(0, 1) == 1)
      repeat ($urandom_range(1, 3)) chars.push_back(pick_char(1'b0));
    if (want_el != 0 || $urandom_range(0, 1) == 1) begin
      chars.push_back(CharDot);
      for (int i = 0; i < want_el; i++) chars.push_back(mixed_case(want_ext[i*8 +: 8]));
      if (want_el == ExtLen && $urandom_range(0, 1) == 1)
        repeat ($urandom_range(1, 3)) chars.push_back(pick_char(1'b1));
    end
    if (chars.size() == 0 || $urandom_range(0, 7) == 0) chars.push_back(8'h00);
    foreach (chars[i]) begin
      // entries slipped in mid-query are ignored by the block
      if (noisy && i != 0 && $urandom_range(0, 2) == 0) push_txn(any_entry());
      push_txn(char_txn(chars[i], i == chars.size() - 1));
    end
  endtask

  // Directory scan that ends in a hit, an end marker or exhaustion
  task automatic run_search();
    int unsigned hit_at;
    int unsigned end_at;
    hit_at = $urandom_range(0, DirEntries + DirEntries / 2);
    end_at = ($urandom_range(0, 3) == 0) ? $urandom_range(0, DirEntries - 1) : DirEntries;
    for (int i = 0; i < DirEntries; i++) begin
      if (i == end_at) begin
        push_txn(entry_txn(ENT_END));
        break;
      end
      if (i == hit_at) begin
        push_txn(entry_txn(ENT_HIT));
        break;
      end
      push_txn(entry_txn(filler_kind()));
    end
    if ($urandom_range(0, 4) == 0) repeat ($urandom_range(1, 3)) push_txn(any_entry());
  endtask

  task automatic random_sequence();
    in_item_t t;
    case ($urandom_range(0, 9))
      7: begin
        pick_target();
        send_query(1'b1);
        run_search();
      end
      8: begin
        // scan left unfinished; the next query aborts it
        pick_target();
        send_query(1'b0);
        repeat ($urandom_range(1, 4)) push_txn(entry_txn(filler_kind()));
      end
      9: begin
        repeat ($urandom_range(1, 6)) begin
          t           = any_entry();
          t.command   = 1'($urandom);
          t.last_char = ($urandom_range(0, 2) == 0);
          push_txn(t);
        end
      end
      default: begin
        pick_target();
        send_query(1'b0);
        run_search();
      end
    endcase
  endtask

  initial begin
    in_item_t    t;
    logic [31:0] base;
    rst_ni        <= 1'b0;
    in_valid      <= 1'b0;
    in_data       <= '0;
    cfg_valid     <= 1'b0;
    cfg_data      <= '0;
    quiet_cycles  <= 0;
    txn_count     = 0;
    setting_count = 0;
    steady_flow   = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: entry before any query, all ones, is ignored
    t         = '1;
    t.command = CMD_ENTRY;
    push_txn(t);
    // "f", zero character, 0xFF, dot, "a" packs to F<FF>.A
    push_txn(char_txn("f", 1'b0));
    push_txn(char_txn(8'h00, 1'b0));
    push_txn(char_txn(8'hFF, 1'b0));
    push_txn(char_txn(CharDot, 1'b0));
    push_txn(char_txn("a", 1'b1));
    want_name = {{6{CharSpace}}, 8'hFF, 8'h46};
    want_ext  = {{2{CharSpace}}, 8'h41};
    push_txn(entry_txn(ENT_DELETED));
    push_txn(entry_txn(ENT_LONG));
    t            = entry_txn(ENT_HIT);
    t.entry_attr = 8'hFF;
    t.entry_size = '1;
    push_txn(t);
    // Only dots: blank name, later dots fill the extension and overflow
    repeat (4) push_txn(char_txn(CharDot, 1'b0));
    push_txn(char_txn(CharDot, 1'b1));
    push_txn(entry_txn(ENT_END));
    // All-zero entry after the search ended is ignored
    t         = '0;
    t.command = CMD_ENTRY;
    push_txn(t);
    // Smallest character, matched at index zero
    push_txn(char_txn(8'h01, 1'b1));
    want_name = {{7{CharSpace}}, 8'h01};
    want_ext  = ExtBlank;
    push_txn(entry_txn(ENT_HIT));

    // Random phases, each under its own sector base
    for (int p = 0; p < Phases; p++) begin
      case (p)
        0:       base = 32'h0000_0000;
        1:       base = 32'hFFFF_FFFF;
        2:       base = 32'hFFFF_FFF8;
        3:       base = 32'h8000_0000;
        7:       base = DataStartReset;
        default: base = $urandom;
      endcase
      write_start_sector(base);
      steady_flow = (p == 2 || p == 5);
      while (txn_count < (p + 1) * (RandomTxns / Phases)) random_sequence();
    end
    steady_flow = 1'b0;

    drain_lookups();
    $display("Summary: %0d transactions sent, %0d lookups checked (%0d found)",
             txn_count, lookup_count, hit_count);
    $display("         across %0d sector base settings after the reset value", setting_count);
    if (fail_count == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
